// ===== rtl/lzwd_pkg.sv =====
// Shared types and constants for the LZW strip decoder.
package lzwd_pkg;

    localparam logic [1:0] CMD_PUSH  = 2'd0;
    localparam logic [1:0] CMD_PULL  = 2'd1;
    localparam logic [1:0] CMD_START = 2'd2;

    localparam logic [1:0] ST_RUN     = 2'd0;
    localparam logic [1:0] ST_END     = 2'd1;
    localparam logic [1:0] ST_INVALID = 2'd2;
    localparam logic [1:0] ST_LIMIT   = 2'd3;

    localparam logic [12:0] TABLE_SIZE = 13'd4096;
    localparam logic [11:0] CODE_CLEAR = 12'd256;
    localparam logic [11:0] CODE_END   = 12'd257;
    localparam logic [12:0] FIRST_FREE = 13'd258;
    localparam logic [12:0] GROW_10    = 13'd511;
    localparam logic [12:0] GROW_11    = 13'd1023;
    localparam logic [12:0] GROW_12    = 13'd2047;
    localparam logic [3:0]  INIT_WIDTH = 4'd9;

    typedef struct packed {
        logic [1:0] command;
        logic [7:0] data_byte;
    } item_t;

    typedef struct packed {
        logic [1:0]  status;
        logic        accepted;
        logic        more_pending;
        logic [3:0]  byte_count;
        logic [63:0] out_bytes;
    } result_t;

endpackage

// ===== rtl/lzw_variable_width_decoder_core.sv =====
// Top level of the TIFF-style LZW strip decoder.
// Takes push, pull and new-strip words on the slave stream and returns one result word
// per command on the master stream. A two-word input queue keeps accepting while the
// engine works or a result waits; the engine takes the next word only once the previous
// result has left. A code whose dictionary chain has to be expanded is walked twice:
// one chain walk counts the string and one writes it out, and every dictionary read
// is registered. A pull returns up to PULL_BYTES bytes.
module lzw_variable_width_decoder_core
#(
    parameter int PULL_BYTES = 8
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_we,
    input  logic [31:0] cfg_wdata,    // output_limit
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,      // data_byte
    input  logic [1:0]  s_tuser,      // command
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [71:0] m_tdata       // out_bytes, byte_count, more_pending, accepted, status
);

    lzwd_pkg::item_t   s_item;
    lzwd_pkg::item_t   q_item;
    lzwd_pkg::result_t m_result;
    logic              q_valid;
    logic              q_pop;

    assign s_item.command   = s_tuser;
    assign s_item.data_byte = s_tdata;
    assign m_tdata          = m_result;

    lzwd_front u_front
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_item   (s_item),
        .q_valid  (q_valid),
        .q_pop    (q_pop),
        .q_item   (q_item)
    );

    lzwd_back #(.PULL_BYTES(PULL_BYTES)) u_back
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata),
        .q_valid   (q_valid),
        .q_pop     (q_pop),
        .q_item    (q_item),
        .m_valid   (m_tvalid),
        .m_ready   (m_tready),
        .m_result  (m_result)
    );

endmodule

// ===== rtl/lzwd_front.sv =====
// Input word queue between the stream slave port and the decode engine.
module lzwd_front
(
    input  logic            clk,
    input  logic            rst_n,
    input  logic            s_tvalid,
    output logic            s_tready,
    input  lzwd_pkg::item_t s_item,
    output logic            q_valid,
    input  logic            q_pop,
    output lzwd_pkg::item_t q_item
);

    lzwd_pkg::item_t q_reg [2];
    logic            wr_ptr_reg;
    logic            rd_ptr_reg;
    logic [1:0]      count_reg;
    logic            push;
    logic            pop;

    assign s_tready = (count_reg != 2'd2);
    assign q_valid  = (count_reg != 2'd0);
    assign q_item   = q_reg[rd_ptr_reg];
    assign push     = s_tvalid && s_tready;
    assign pop      = q_pop && q_valid;

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            q_reg[wr_ptr_reg] <= s_item;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end
        else
        begin
            if (push)
            begin
                wr_ptr_reg <= ~wr_ptr_reg;
            end
            if (pop)
            begin
                rd_ptr_reg <= ~rd_ptr_reg;
            end
            count_reg <= count_reg + {1'b0, push} - {1'b0, pop};
        end
    end

endmodule

// ===== rtl/lzwd_back.sv =====
// Decode engine: bit unpacking, dictionary walk, string buffer and result register.
module lzwd_back
#(
    parameter int PULL_BYTES = 8
)
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              cfg_we,
    input  logic [31:0]       cfg_wdata,
    input  logic              q_valid,
    output logic              q_pop,
    input  lzwd_pkg::item_t   q_item,
    output logic              m_valid,
    input  logic              m_ready,
    output lzwd_pkg::result_t m_result
);

    localparam logic [3:0] S_IDLE     = 4'd0;
    localparam logic [3:0] S_EXEC     = 4'd1;
    localparam logic [3:0] S_PULL_RD  = 4'd2;
    localparam logic [3:0] S_PULL_CAP = 4'd3;
    localparam logic [3:0] S_CNT_RD   = 4'd4;
    localparam logic [3:0] S_CNT_ST   = 4'd5;
    localparam logic [3:0] S_FILL_RD  = 4'd6;
    localparam logic [3:0] S_FILL_WR  = 4'd7;
    localparam logic [3:0] S_ADD      = 4'd8;
    localparam logic [3:0] S_EMIT     = 4'd9;
    localparam logic [3:0] S_CHECK    = 4'd10;
    localparam logic [3:0] S_DONE     = 4'd11;

    logic [19:0] dict_mem [4096];
    logic [7:0]  sb_mem [4096];
    logic [19:0] dict_rdata_reg;
    logic [7:0]  sb_rdata_reg;

    logic [3:0]  state_reg, state_next;
    logic [31:0] limit_reg;
    lzwd_pkg::item_t item_reg, item_next;
    logic [23:0] acc_reg, acc_next;
    logic [4:0]  bits_reg, bits_next;
    logic [3:0]  width_reg, width_next;
    logic [12:0] nfc_reg, nfc_next;
    logic [11:0] prev_reg, prev_next;
    logic        pv_reg, pv_next;
    logic [12:0] pending_reg, pending_next;
    logic [12:0] drain_reg, drain_next;
    logic [31:0] emitted_reg, emitted_next;
    logic [1:0]  status_reg, status_next;
    logic [12:0] cur_reg, cur_next;
    logic [12:0] start_reg, start_next;
    logic [12:0] n_reg, n_next;
    logic [12:0] len_reg, len_next;
    logic [11:0] idx_reg, idx_next;
    logic        kwk_reg, kwk_next;
    logic [11:0] code_reg, code_next;
    logic [7:0]  first_reg, first_next;
    logic [63:0] bytes_reg, bytes_next;
    logic [3:0]  cnt_reg, cnt_next;
    logic        acc_ok_reg, acc_ok_next;
    logic        out_valid_reg;
    lzwd_pkg::result_t out_reg;

    logic        dict_we;
    logic [11:0] dict_waddr;
    logic [19:0] dict_wdata;
    logic [11:0] dict_raddr;
    logic        sb_we;
    logic [11:0] sb_waddr;
    logic [7:0]  sb_wdata;
    logic [11:0] sb_raddr;

    logic [23:0] acc_cat;
    logic [4:0]  bits_sum;
    logic [4:0]  shamt;
    logic [23:0] shifted;
    logic [12:0] mask;
    logic [11:0] code;
    logic [31:0] room;
    logic [31:0] kept;
    logic [12:0] nfc_inc;

    assign acc_cat  = {acc_reg[15:0], item_reg.data_byte};
    assign bits_sum = bits_reg + 5'd8;
    assign shamt    = bits_sum - {1'b0, width_reg};
    assign shifted  = acc_cat >> shamt;
    assign mask     = (13'd1 << width_reg) - 13'd1;
    assign code     = shifted[11:0] & mask[11:0];
    assign room     = limit_reg - emitted_reg;
    assign kept     = ({19'd0, len_reg} < room) ? {19'd0, len_reg} : room;
    assign nfc_inc  = nfc_reg + 13'd1;

    assign q_pop    = (state_reg == S_IDLE) && q_valid && !out_valid_reg;
    assign m_valid  = out_valid_reg;
    assign m_result = out_reg;

    always_ff @(posedge clk)
    begin
        if (dict_we)
        begin
            dict_mem[dict_waddr] <= dict_wdata;
        end
        dict_rdata_reg <= dict_mem[dict_raddr];
    end

    always_ff @(posedge clk)
    begin
        if (sb_we)
        begin
            sb_mem[sb_waddr] <= sb_wdata;
        end
        sb_rdata_reg <= sb_mem[sb_raddr];
    end

    always_comb
    begin
        state_next   = state_reg;
        item_next    = item_reg;
        acc_next     = acc_reg;
        bits_next    = bits_reg;
        width_next   = width_reg;
        nfc_next     = nfc_reg;
        prev_next    = prev_reg;
        pv_next      = pv_reg;
        pending_next = pending_reg;
        drain_next   = drain_reg;
        emitted_next = emitted_reg;
        status_next  = status_reg;
        cur_next     = cur_reg;
        start_next   = start_reg;
        n_next       = n_reg;
        len_next     = len_reg;
        idx_next     = idx_reg;
        kwk_next     = kwk_reg;
        code_next    = code_reg;
        first_next   = first_reg;
        bytes_next   = bytes_reg;
        cnt_next     = cnt_reg;
        acc_ok_next  = acc_ok_reg;
        dict_we      = 1'b0;
        dict_waddr   = nfc_reg[11:0];
        dict_wdata   = {prev_reg, first_reg};
        dict_raddr   = cur_reg[11:0];
        sb_we        = 1'b0;
        sb_waddr     = idx_reg;
        sb_wdata     = dict_rdata_reg[7:0];
        sb_raddr     = drain_reg[11:0];

        unique case (state_reg)
            S_IDLE:
            begin
                if (q_pop)
                begin
                    item_next  = q_item;
                    bytes_next = 64'd0;
                    cnt_next   = 4'd0;
                    acc_ok_next = 1'b0;
                    state_next = S_EXEC;
                end
            end
            S_EXEC:
            begin
                state_next = S_DONE;
                case (item_reg.command)
                    lzwd_pkg::CMD_PUSH:
                    begin
                        if (status_reg == lzwd_pkg::ST_RUN && drain_reg >= pending_reg)
                        begin
                            if (emitted_reg >= limit_reg)
                            begin
                                status_next = lzwd_pkg::ST_LIMIT;
                            end
                            else
                            begin
                                acc_ok_next = 1'b1;
                                acc_next    = acc_cat;
                                bits_next   = bits_sum;
                                if (bits_sum >= {1'b0, width_reg})
                                begin
                                    bits_next = shamt;
                                    if (code == lzwd_pkg::CODE_END)
                                    begin
                                        status_next = lzwd_pkg::ST_END;
                                    end
                                    else if (code == lzwd_pkg::CODE_CLEAR)
                                    begin
                                        width_next = lzwd_pkg::INIT_WIDTH;
                                        nfc_next   = lzwd_pkg::FIRST_FREE;
                                        pv_next    = 1'b0;
                                    end
                                    else if (!pv_reg)
                                    begin
                                        if (code < 12'd256)
                                        begin
                                            sb_we      = 1'b1;
                                            sb_waddr   = 12'd0;
                                            sb_wdata   = code[7:0];
                                            len_next   = 13'd1;
                                            prev_next  = code;
                                            pv_next    = 1'b1;
                                            state_next = S_EMIT;
                                        end
                                    end
                                    else if ({1'b0, code} < nfc_reg)
                                    begin
                                        cur_next   = {1'b0, code};
                                        start_next = {1'b0, code};
                                        code_next  = code;
                                        n_next     = 13'd1;
                                        kwk_next   = 1'b0;
                                        state_next = S_CNT_RD;
                                    end
                                    else if ({1'b0, code} == nfc_reg)
                                    begin
                                        cur_next   = {1'b0, prev_reg};
                                        start_next = {1'b0, prev_reg};
                                        code_next  = code;
                                        n_next     = 13'd1;
                                        kwk_next   = 1'b1;
                                        state_next = S_CNT_RD;
                                    end
                                    else
                                    begin
                                        status_next = lzwd_pkg::ST_INVALID;
                                    end
                                end
                            end
                        end
                    end
                    lzwd_pkg::CMD_PULL:
                    begin
                        state_next = S_PULL_RD;
                    end
                    lzwd_pkg::CMD_START:
                    begin
                        acc_next     = 24'd0;
                        bits_next    = 5'd0;
                        width_next   = lzwd_pkg::INIT_WIDTH;
                        nfc_next     = lzwd_pkg::FIRST_FREE;
                        prev_next    = 12'd0;
                        pv_next      = 1'b0;
                        pending_next = 13'd0;
                        drain_next   = 13'd0;
                        emitted_next = 32'd0;
                        status_next  = lzwd_pkg::ST_RUN;
                    end
                    default:
                    begin
                        state_next = S_DONE;
                    end
                endcase
            end
            S_PULL_RD:
            begin
                if (cnt_reg == 4'(PULL_BYTES) || drain_reg >= pending_reg)
                begin
                    state_next = S_DONE;
                end
                else
                begin
                    state_next = S_PULL_CAP;
                end
            end
            S_PULL_CAP:
            begin
                bytes_next[{cnt_reg[2:0], 3'b000} +: 8] = sb_rdata_reg;
                drain_next = drain_reg + 13'd1;
                cnt_next   = cnt_reg + 4'd1;
                state_next = S_PULL_RD;
            end
            S_CNT_RD:
            begin
                if (cur_reg >= lzwd_pkg::FIRST_FREE)
                begin
                    state_next = S_CNT_ST;
                end
                else
                begin
                    idx_next   = 12'(n_reg - 13'd1);
                    cur_next   = start_reg;
                    state_next = S_FILL_RD;
                end
            end
            S_CNT_ST:
            begin
                n_next     = n_reg + 13'd1;
                cur_next   = {1'b0, dict_rdata_reg[19:8]};
                state_next = S_CNT_RD;
            end
            S_FILL_RD:
            begin
                if (cur_reg >= lzwd_pkg::FIRST_FREE)
                begin
                    state_next = S_FILL_WR;
                end
                else
                begin
                    sb_we      = 1'b1;
                    sb_wdata   = cur_reg[7:0];
                    first_next = cur_reg[7:0];
                    state_next = S_ADD;
                end
            end
            S_FILL_WR:
            begin
                sb_we      = 1'b1;
                cur_next   = {1'b0, dict_rdata_reg[19:8]};
                idx_next   = idx_reg - 12'd1;
                state_next = S_FILL_RD;
            end
            S_ADD:
            begin
                if (kwk_reg)
                begin
                    sb_we    = 1'b1;
                    sb_waddr = n_reg[11:0];
                    sb_wdata = first_reg;
                end
                if (nfc_reg < lzwd_pkg::TABLE_SIZE)
                begin
                    dict_we  = 1'b1;
                    nfc_next = nfc_inc;
                    if (nfc_inc == lzwd_pkg::GROW_10)
                    begin
                        width_next = 4'd10;
                    end
                    else if (nfc_inc == lzwd_pkg::GROW_11)
                    begin
                        width_next = 4'd11;
                    end
                    else if (nfc_inc == lzwd_pkg::GROW_12)
                    begin
                        width_next = 4'd12;
                    end
                end
                len_next   = n_reg + {12'd0, kwk_reg};
                prev_next  = code_reg;
                state_next = S_EMIT;
            end
            S_EMIT:
            begin
                pending_next = kept[12:0];
                drain_next   = 13'd0;
                emitted_next = emitted_reg + kept;
                state_next   = S_CHECK;
            end
            S_CHECK:
            begin
                if (emitted_reg >= limit_reg)
                begin
                    status_next = lzwd_pkg::ST_LIMIT;
                end
                state_next = S_DONE;
            end
            S_DONE:
            begin
                state_next = S_IDLE;
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk)
    begin
        item_reg  <= item_next;
        cur_reg   <= cur_next;
        start_reg <= start_next;
        n_reg     <= n_next;
        len_reg   <= len_next;
        idx_reg   <= idx_next;
        kwk_reg   <= kwk_next;
        code_reg  <= code_next;
        first_reg <= first_next;
        bytes_reg <= bytes_next;
        cnt_reg   <= cnt_next;
        acc_ok_reg <= acc_ok_next;
        if (state_reg == S_DONE)
        begin
            out_reg.out_bytes    <= bytes_reg;
            out_reg.byte_count   <= cnt_reg;
            out_reg.more_pending <= (drain_reg < pending_reg);
            out_reg.accepted     <= acc_ok_reg;
            out_reg.status       <= status_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            limit_reg     <= 32'hFFFF_FFFF;
            acc_reg       <= 24'd0;
            bits_reg      <= 5'd0;
            width_reg     <= lzwd_pkg::INIT_WIDTH;
            nfc_reg       <= lzwd_pkg::FIRST_FREE;
            prev_reg      <= 12'd0;
            pv_reg        <= 1'b0;
            pending_reg   <= 13'd0;
            drain_reg     <= 13'd0;
            emitted_reg   <= 32'd0;
            status_reg    <= lzwd_pkg::ST_RUN;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg   <= state_next;
            acc_reg     <= acc_next;
            bits_reg    <= bits_next;
            width_reg   <= width_next;
            nfc_reg     <= nfc_next;
            prev_reg    <= prev_next;
            pv_reg      <= pv_next;
            pending_reg <= pending_next;
            drain_reg   <= drain_next;
            emitted_reg <= emitted_next;
            status_reg  <= status_next;
            if (cfg_we)
            begin
                limit_reg <= cfg_wdata;
            end
            if (state_reg == S_DONE)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (m_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

endmodule

// ===== rtl/lzwd_checker.sv =====
// Port-level checks for the LZW strip decoder and their binding.
module lzwd_checker
(
    input logic        clk,
    input logic        rst_n,
    input logic        m_tvalid,
    input logic        m_tready,
    input logic [71:0] m_tdata
);

    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
        else $error("result word dropped or changed while stalled");

    a_count: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> m_tdata[67:64] <= 4'd8)
        else $error("byte count above eight");

    a_push_no_bytes: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && m_tdata[69] |-> m_tdata[67:64] == 4'd0 && m_tdata[63:0] == 64'd0)
        else $error("accepted push carries output bytes");

endmodule

bind lzw_variable_width_decoder_core lzwd_checker u_lzwd_checker
(
    .clk      (clk),
    .rst_n    (rst_n),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
);
